/* hdl/pid_pkg.sv */
package pid_pkg;

   // Fixed-point format of the gains and the term limits
   localparam int GAIN_FRAC_BITS = 8;
   localparam logic [14:0] P_LIMIT = 15'd32767;
   localparam logic [14:0] D_LIMIT = 15'd32767;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int ERR_W    = 17;
   localparam int DIFF_W   = 18;
   localparam int GAIN_W   = 16;
   localparam int LIM_W    = 15;
   localparam int PROD_W   = GAIN_W + 1 + ERR_W;
   localparam int PRODD_W  = GAIN_W + 1 + DIFF_W;
   localparam int SAT_W    = PRODD_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P    = 3'd0,
      CSR_GAIN_I    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_DEAD_BAND = 3'd3,
      CSR_INT_ZONE  = 3'd4,
      CSR_ERR_MAX   = 3'd5,
      CSR_INT_MAX   = 3'd6,
      CSR_OUT_MAX   = 3'd7
   } pid_csr_idx_type;

   // Item opcodes
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [15:0]       dead_band;
      logic [15:0]       integral_zone;
      logic [15:0]       error_max;
      logic [LIM_W-1:0]  integral_max;
      logic [LIM_W-1:0]  output_max;
   } pid_cfg_type;

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] setpoint;
      logic signed [SAMPLE_W-1:0] feedback;
   } pid_item_type;

   // Word passed from the error stage to the sum stage
   typedef struct packed {
      logic                      op_clear;
      logic                      dead;
      logic                      in_zone;
      logic signed [PROD_W-1:0]  prod_p;
      logic signed [PROD_W-1:0]  prod_i;
      logic signed [PRODD_W-1:0] prod_d;
   } pid_work_type;

   // Symmetric saturation to +/- lim
   function automatic logic signed [SAMPLE_W-1:0] sat_sym(
      input logic signed [SAT_W-1:0] x,
      input logic [LIM_W-1:0]        lim
   );
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      logic signed [SAT_W-1:0] res;
      hi = $signed({{(SAT_W-LIM_W){1'b0}}, lim});
      lo = -hi;
      if (x > hi) begin
         res = hi;
      end else if (x < lo) begin
         res = lo;
      end else begin
         res = x;
      end
      return res[SAMPLE_W-1:0];
   endfunction

endpackage

/* hdl/pid_chan_if.sv */
interface pid_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic signed [pid_pkg::SAMPLE_W-1:0] setpoint;
   logic signed [pid_pkg::SAMPLE_W-1:0] feedback;

   modport source (output valid, output op, output setpoint, output feedback, input ready);
   modport sink (input valid, input op, input setpoint, input feedback, output ready);
endinterface

interface pid_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pid_pkg::SAMPLE_W-1:0] drive;
   logic                                in_deadband;

   modport source (output valid, output drive, output in_deadband, input ready);
   modport sink (input valid, input drive, input in_deadband, output ready);
endinterface

/* hdl/pid_with_deadband_and_limits.sv */
// A word accepted on req_ch passes the input register, the error/product stage
// and the sum/saturation stage before it shows on rsp_ch. Throughput: one word
// per cycle while rsp_ch is ready; each stage moves on as soon as the next frees.
// Reset (synchronous, active high): empties the pipeline, zeroes the previous
// error and the integral, and returns the configuration registers to their defaults.
module pid_with_deadband_and_limits (
   input  logic                           clock,
   input  logic                           reset,
   pid_req_if.sink                        req_ch,
   pid_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [pid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pid_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pid_pkg::*;

   pid_cfg_type   cfg;
   logic          in_valid_ff;
   logic          in_valid_in;
   pid_item_type  item_ff;
   pid_item_type  item_in;
   logic          err_ready;
   logic          work_valid;
   logic          sum_ready;
   pid_work_type  work;
   logic          accept;

   pid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register: take a word when empty or when it moves on
   assign req_ch.ready = !in_valid_ff || err_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;

   always_comb begin
      item_in.op       = req_ch.op;
      item_in.setpoint = req_ch.setpoint;
      item_in.feedback = req_ch.feedback;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   pid_err u_err (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_ready  (err_ready),
      .in_item   (item_ff),
      .out_valid (work_valid),
      .out_ready (sum_ready),
      .out_work  (work)
   );

   pid_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (work_valid),
      .in_ready  (sum_ready),
      .in_work   (work),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_drive (rsp_ch.drive),
      .out_dead  (rsp_ch.in_deadband)
   );

   // A deadband result never carries drive
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.in_deadband) |-> (rsp_ch.drive == '0))
      else $error("deadband result with nonzero drive");

   // Reset empties the input register and the result stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !rsp_ch.valid))
      else $error("pipeline not empty after reset");

   // A word blocked in the input register stays put
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !err_ready) |=> (in_valid_ff && $stable(item_ff)))
      else $error("stalled input word lost or changed");

endmodule

/* hdl/pid_csr.sv */
module pid_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [pid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pid_pkg::CSR_DATA_W-1:0] csr_wdata,
   output pid_pkg::pid_cfg_type           cfg
);
   import pid_pkg::*;

   pid_cfg_type cfg_ff;
   pid_cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_P:    cfg_in.gain_p        = csr_wdata;
            CSR_GAIN_I:    cfg_in.gain_i        = csr_wdata;
            CSR_GAIN_D:    cfg_in.gain_d        = csr_wdata;
            CSR_DEAD_BAND: cfg_in.dead_band     = csr_wdata;
            CSR_INT_ZONE:  cfg_in.integral_zone = csr_wdata;
            CSR_ERR_MAX:   cfg_in.error_max     = csr_wdata;
            CSR_INT_MAX:   cfg_in.integral_max  = csr_wdata[LIM_W-1:0];
            CSR_OUT_MAX:   cfg_in.output_max    = csr_wdata[LIM_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p        <= '0;
         cfg_ff.gain_i        <= '0;
         cfg_ff.gain_d        <= '0;
         cfg_ff.dead_band     <= '0;
         cfg_ff.integral_zone <= '0;
         cfg_ff.error_max     <= '1;
         cfg_ff.integral_max  <= '1;
         cfg_ff.output_max    <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/pid_err.sv */
module pid_err (
   input  logic                  clock,
   input  logic                  reset,
   input  pid_pkg::pid_cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pid_pkg::pid_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pid_pkg::pid_work_type out_work
);
   import pid_pkg::*;

   logic                      valid_ff;
   logic                      valid_in;
   pid_work_type              work_ff;
   pid_work_type              work_in;
   logic signed [ERR_W-1:0]   prev_ff;
   logic signed [ERR_W-1:0]   prev_in;

   logic signed [ERR_W-1:0]   raw;
   logic signed [ERR_W-1:0]   neg_raw;
   logic [15:0]               mag;
   logic signed [ERR_W-1:0]   emax;
   logic signed [ERR_W-1:0]   err;
   logic signed [DIFF_W-1:0]  diff;
   logic                      load;

   // Raw error, its magnitude and the clamped error
   always_comb begin
      raw     = ERR_W'(in_item.setpoint) - ERR_W'(in_item.feedback);
      neg_raw = -raw;
      mag     = raw[ERR_W-1] ? neg_raw[15:0] : raw[15:0];
      emax    = $signed({1'b0, cfg.error_max});
      if (raw > emax) begin
         err = emax;
      end else if (raw < -emax) begin
         err = -emax;
      end else begin
         err = raw;
      end
      diff = DIFF_W'(err) - DIFF_W'(prev_ff);
   end

   // Flags and the three gain products
   always_comb begin
      work_in.op_clear = (in_item.op == OP_CLEAR);
      work_in.dead     = (mag < cfg.dead_band);
      work_in.in_zone  = (mag < cfg.integral_zone);
      work_in.prod_p   = $signed({1'b0, cfg.gain_p}) * err;
      work_in.prod_i   = $signed({1'b0, cfg.gain_i}) * err;
      work_in.prod_d   = $signed({1'b0, cfg.gain_d}) * diff;
   end

   // Advance when the stage is empty or the sum stage takes the word
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign prev_in  = !load ? prev_ff : (work_in.op_clear ? '0 : err);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         prev_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

/* hdl/pid_sum.sv */
module pid_sum (
   input  logic                                clock,
   input  logic                                reset,
   input  pid_pkg::pid_cfg_type                cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  pid_pkg::pid_work_type               in_work,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [pid_pkg::SAMPLE_W-1:0] out_drive,
   output logic                                out_dead
);
   import pid_pkg::*;

   logic                         valid_ff;
   logic                         valid_in;
   logic signed [SAMPLE_W-1:0]   drive_ff;
   logic signed [SAMPLE_W-1:0]   drive_in;
   logic                         dead_ff;
   logic                         dead_in;
   logic signed [SAMPLE_W-1:0]   integ_ff;
   logic signed [SAMPLE_W-1:0]   integ_in;

   logic signed [PROD_W-1:0]     sh_p;
   logic signed [PROD_W-1:0]     sh_i;
   logic signed [PRODD_W-1:0]    sh_d;
   logic signed [SAMPLE_W-1:0]   term_p;
   logic signed [SAMPLE_W-1:0]   term_d;
   logic signed [SAMPLE_W-1:0]   integ_acc;
   logic signed [SAMPLE_W-1:0]   integ_new;
   logic signed [SAT_W-1:0]      total;
   logic                         load;

   // Scale the products, saturate each term and add them up
   always_comb begin
      sh_p      = in_work.prod_p >>> GAIN_FRAC_BITS;
      sh_i      = in_work.prod_i >>> GAIN_FRAC_BITS;
      sh_d      = in_work.prod_d >>> GAIN_FRAC_BITS;
      term_p    = sat_sym(SAT_W'(sh_p), P_LIMIT);
      term_d    = sat_sym(SAT_W'(sh_d), D_LIMIT);
      integ_acc = sat_sym(SAT_W'(integ_ff) + SAT_W'(sh_i), cfg.integral_max);
      integ_new = in_work.in_zone ? integ_acc : '0;
      total     = SAT_W'(term_p) + SAT_W'(integ_new) + SAT_W'(term_d);
   end

   // Pick the result: clear and deadband give zero drive
   always_comb begin
      if (in_work.op_clear) begin
         drive_in = '0;
         dead_in  = 1'b0;
      end else if (in_work.dead) begin
         drive_in = '0;
         dead_in  = 1'b1;
      end else begin
         drive_in = sat_sym(total, cfg.output_max);
         dead_in  = 1'b0;
      end
   end

   // Hold the result until taken; take a new word when free
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign integ_in = !load ? integ_ff :
                     ((in_work.op_clear || in_work.dead) ? '0 : integ_new);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         integ_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
         dead_ff  <= dead_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_drive = drive_ff;
   assign out_dead  = dead_ff;

endmodule
